/* src/mtre_pkg.sv */
// ----------------------------------------------------------------------------
// mtre_pkg
// Shared types and constants for the TLB refill exception entry block.
// ----------------------------------------------------------------------------
package mtre_pkg;

    // Default number of TLB entries whose address ranges are held.
    localparam int unsigned MTRE_TLB_ENTRIES_DEF = 32;

    // Item action codes.
    localparam logic [1:0] ACT_TLB_REFILL = 2'd0;
    localparam logic [1:0] ACT_GENERAL    = 2'd1;
    localparam logic [1:0] ACT_LOAD_RANGE = 2'd2;
    localparam logic [1:0] ACT_REG_WRITE  = 2'd3;

    // Access kinds.
    localparam logic [1:0] ACC_LOAD  = 2'd0;
    localparam logic [1:0] ACC_STORE = 2'd1;
    localparam logic [1:0] ACC_FETCH = 2'd2;

    // Register select codes for a register write.
    localparam logic [1:0] SEL_CAUSE   = 2'd0;
    localparam logic [1:0] SEL_STATUS  = 2'd1;
    localparam logic [1:0] SEL_CONTEXT = 2'd2;
    localparam logic [1:0] SEL_EPC     = 2'd3;

    // Coprocessor constants.
    localparam logic [31:0] CAUSE_STORE_CODE = 32'h0000_000C;
    localparam logic [31:0] CAUSE_LOAD_CODE  = 32'h0000_0008;
    localparam logic [31:0] CONTEXT_KEEP     = 32'hFF80_000F;
    localparam logic [31:0] CONTEXT_VPN_MASK = 32'h007F_FFF0;
    localparam logic [31:0] ENTRY_HI_MASK    = 32'hFFFF_E000;
    localparam logic [31:0] VEC_GENERAL      = 32'h8000_0180;
    localparam logic [31:0] VEC_REFILL       = 32'h8000_0000;
    localparam int unsigned STATUS_EXL_BIT   = 1;
    localparam int unsigned CAUSE_BD_BIT     = 31;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_DONE  = 4'b1000
    } mtre_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit;
    } mtre_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } mtre_status_t;

endpackage

/* src/mtre_ctrl.sv */
// ----------------------------------------------------------------------------
// mtre_ctrl
// Controller: sequences capture, TLB range scan and commit of one word.
// ----------------------------------------------------------------------------
module mtre_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mtre_pkg::mtre_status_t stat,
    output mtre_pkg::mtre_cmd_t    cmd
);
    import mtre_pkg::*;

    mtre_state_t state_reg;
    mtre_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = stat.need_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/mtre_datapath.sv */
// ----------------------------------------------------------------------------
// mtre_datapath
// Coprocessor registers, TLB range memories with scan comparators, and the
// output register.
// ----------------------------------------------------------------------------
module mtre_datapath #(
    parameter int unsigned TLB_ENTRIES = mtre_pkg::MTRE_TLB_ENTRIES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             s_action,
    input  logic [31:0]            s_fault_address,
    input  logic [1:0]             s_access_kind,
    input  logic [31:0]            s_resume_pc,
    input  logic [1:0]             s_delay_slot_kind,
    input  logic [4:0]             s_entry_index,
    input  logic                   s_odd_half,
    input  logic [31:0]            s_range_start,
    input  logic [31:0]            s_range_end,
    input  logic [1:0]             s_register_select,
    input  logic [31:0]            s_register_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_vector_pc,
    output logic [31:0]            m_epc_out,
    output logic [31:0]            m_cause_out,
    output logic [31:0]            m_status_out,
    output logic [31:0]            m_context_out,
    output logic [31:0]            m_bad_address_out,
    output logic [31:0]            m_entry_high_out,
    output logic                   m_skip_jump_valid,
    output logic                   m_clear_next_interrupt,
    input  mtre_pkg::mtre_cmd_t    cmd,
    output mtre_pkg::mtre_status_t stat
);
    import mtre_pkg::*;

    localparam int unsigned IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    // Captured item.
    logic [1:0]  act_reg;
    logic [31:0] addr_reg;
    logic [1:0]  kind_reg;
    logic [31:0] rpc_reg;
    logic [1:0]  ds_reg;
    logic [4:0]  idx_reg;
    logic        odd_reg;
    logic [31:0] rstart_reg;
    logic [31:0] rend_reg;
    logic [1:0]  sel_reg;
    logic [31:0] rval_reg;

    // Coprocessor registers.
    logic [31:0] cause_reg, cause_next;
    logic [31:0] status_reg, status_next;
    logic [31:0] context_reg, context_next;
    logic [31:0] epc_reg, epc_next;
    logic [31:0] bad_reg, bad_next;
    logic [31:0] ehi_reg, ehi_next;

    // Range memories: one word per entry holds {end, start}.
    logic [63:0] mem_even [TLB_ENTRIES];
    logic [63:0] mem_odd  [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] val_even_reg;
    logic [TLB_ENTRIES-1:0] val_odd_reg;
    logic [63:0] rd_even_reg;
    logic [63:0] rd_odd_reg;
    logic        rd_even_v_reg;
    logic        rd_odd_v_reg;
    logic        rd_vld_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic        hit_reg;

    // Output register.
    logic        m_valid_reg;
    logic [31:0] vec_reg, vec_next;
    logic        skip_reg, skip_next;

    logic        bd;
    logic        kseg_hit;
    logic        hit_even;
    logic        hit_odd;
    logic        wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [3:0]  epc_dec;

    // Status to the controller.
    assign stat.need_scan = (s_action == ACT_TLB_REFILL) && !status_reg[STATUS_EXL_BIT]
                            && (s_fault_address[31:30] != 2'b10);
    assign stat.scan_last = (ptr_reg == IDX_W'(TLB_ENTRIES - 1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    // Item capture.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg    <= s_action;
            addr_reg   <= s_fault_address;
            kind_reg   <= s_access_kind;
            rpc_reg    <= s_resume_pc;
            ds_reg     <= s_delay_slot_kind;
            idx_reg    <= s_entry_index;
            odd_reg    <= s_odd_half;
            rstart_reg <= s_range_start;
            rend_reg   <= s_range_end;
            sel_reg    <= s_register_select;
            rval_reg   <= s_register_value;
        end
    end

    // Range store write on commit of a range load.
    assign wr_en  = cmd.commit && (act_reg == ACT_LOAD_RANGE)
                    && ({2'b00, idx_reg} < 7'(TLB_ENTRIES));
    assign wr_idx = IDX_W'(idx_reg);

    always_ff @(posedge aclk) begin
        if (wr_en && !odd_reg) begin
            mem_even[wr_idx] <= {rend_reg, rstart_reg};
        end
        if (wr_en && odd_reg) begin
            mem_odd[wr_idx] <= {rend_reg, rstart_reg};
        end
        rd_even_reg <= mem_even[ptr_reg];
        rd_odd_reg  <= mem_odd[ptr_reg];
    end

    // Valid bits: an unwritten half reads as the range 0..0.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_even_reg <= '0;
            val_odd_reg  <= '0;
        end else if (wr_en) begin
            if (odd_reg) begin
                val_odd_reg[wr_idx] <= 1'b1;
            end else begin
                val_even_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // Scan pointer, read tracking and hit accumulation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_step;
            if (cmd.capture) begin
                ptr_reg <= '0;
                hit_reg <= 1'b0;
            end else begin
                if (cmd.scan_step && !stat.scan_last) begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                if (rd_vld_reg && (hit_even || hit_odd)) begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_even_v_reg <= val_even_reg[ptr_reg];
        rd_odd_v_reg  <= val_odd_reg[ptr_reg];
    end

    // Range comparators for the even and odd halves of one entry.
    always_comb begin
        if (rd_even_v_reg) begin
            hit_even = (addr_reg >= rd_even_reg[31:0]) && (addr_reg <= rd_even_reg[63:32]);
        end else begin
            hit_even = (addr_reg == 32'd0);
        end
        if (rd_odd_v_reg) begin
            hit_odd = (addr_reg >= rd_odd_reg[31:0]) && (addr_reg <= rd_odd_reg[63:32]);
        end else begin
            hit_odd = (addr_reg == 32'd0);
        end
    end

    // Register update for the captured item.
    assign bd       = ds_reg[0];
    assign kseg_hit = (addr_reg[31:30] == 2'b10);

    always_comb begin
        cause_next   = cause_reg;
        status_next  = status_reg;
        context_next = context_reg;
        epc_next     = epc_reg;
        bad_next     = bad_reg;
        ehi_next     = ehi_reg;
        vec_next     = rpc_reg;
        skip_next    = 1'b0;
        epc_dec      = 4'd0;
        unique case (act_reg)
            ACT_TLB_REFILL: begin
                cause_next = (kind_reg == ACC_STORE) ? CAUSE_STORE_CODE : CAUSE_LOAD_CODE;
                cause_next[CAUSE_BD_BIT] = bd;
                bad_next     = addr_reg;
                context_next = (context_reg & CONTEXT_KEEP)
                               | ((addr_reg >> 9) & CONTEXT_VPN_MASK);
                ehi_next     = addr_reg & ENTRY_HI_MASK;
                skip_next    = (ds_reg != 2'd0);
                if (status_reg[STATUS_EXL_BIT]) begin
                    vec_next = VEC_GENERAL;
                end else begin
                    epc_dec  = (bd ? 4'd4 : 4'd0) + ((kind_reg != ACC_FETCH) ? 4'd4 : 4'd0);
                    epc_next = rpc_reg - 32'(epc_dec);
                    status_next[STATUS_EXL_BIT] = 1'b1;
                    vec_next = (kseg_hit || hit_reg) ? VEC_GENERAL : VEC_REFILL;
                end
            end
            ACT_GENERAL: begin
                status_next[STATUS_EXL_BIT] = 1'b1;
                cause_next[CAUSE_BD_BIT]    = bd;
                epc_dec   = bd ? 4'd4 : 4'd0;
                epc_next  = rpc_reg - 32'(epc_dec);
                vec_next  = VEC_GENERAL;
                skip_next = (ds_reg != 2'd0);
            end
            ACT_LOAD_RANGE: begin
                vec_next = rpc_reg;
            end
            ACT_REG_WRITE: begin
                unique case (sel_reg)
                    SEL_CAUSE:   cause_next   = rval_reg;
                    SEL_STATUS:  status_next  = rval_reg;
                    SEL_CONTEXT: context_next = rval_reg;
                    SEL_EPC:     epc_next     = rval_reg;
                    default:     epc_next     = rval_reg;
                endcase
            end
            default: begin
                vec_next = rpc_reg;
            end
        endcase
    end

    // Coprocessor registers take the new values on commit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cause_reg   <= '0;
            status_reg  <= '0;
            context_reg <= '0;
            epc_reg     <= '0;
            bad_reg     <= '0;
            ehi_reg     <= '0;
        end else if (cmd.commit) begin
            cause_reg   <= cause_next;
            status_reg  <= status_next;
            context_reg <= context_next;
            epc_reg     <= epc_next;
            bad_reg     <= bad_next;
            ehi_reg     <= ehi_next;
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            vec_reg  <= vec_next;
            skip_reg <= skip_next;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_vector_pc            = vec_reg;
    assign m_epc_out              = epc_reg;
    assign m_cause_out            = cause_reg;
    assign m_status_out           = status_reg;
    assign m_context_out          = context_reg;
    assign m_bad_address_out      = bad_reg;
    assign m_entry_high_out       = ehi_reg;
    assign m_skip_jump_valid      = skip_reg;
    assign m_clear_next_interrupt = skip_reg;

endmodule

/* src/mips_tlb_refill_exception_entry.sv */
// ----------------------------------------------------------------------------
// mips_tlb_refill_exception_entry
// Exception entry of a MIPS system coprocessor: TLB refill and general
// exceptions, TLB range loads and register writes.
//
//   Channel | Direction | Handshake         | Word
//   s_      | in        | s_valid / s_ready | one item: action and operands
//   m_      | out       | m_valid / m_ready | one result: vector and registers
//
// A refill with EXL clear outside kseg0/kseg1 searches both range memories at
// one entry per cycle; any other word skips the search. A new word is taken
// only once the last one has been committed. Reset is synchronous and active
// low; it clears the coprocessor registers, the output valid and the scan
// state, and marks every range as 0..0. A new word is taken while a result
// waits; it then holds until the output register is free.
// ----------------------------------------------------------------------------
module mips_tlb_refill_exception_entry #(
    parameter int unsigned TLB_ENTRIES = mtre_pkg::MTRE_TLB_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_fault_address,
    input  logic [1:0]  s_access_kind,
    input  logic [31:0] s_resume_pc,
    input  logic [1:0]  s_delay_slot_kind,
    input  logic [4:0]  s_entry_index,
    input  logic        s_odd_half,
    input  logic [31:0] s_range_start,
    input  logic [31:0] s_range_end,
    input  logic [1:0]  s_register_select,
    input  logic [31:0] s_register_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_vector_pc,
    output logic [31:0] m_epc_out,
    output logic [31:0] m_cause_out,
    output logic [31:0] m_status_out,
    output logic [31:0] m_context_out,
    output logic [31:0] m_bad_address_out,
    output logic [31:0] m_entry_high_out,
    output logic        m_skip_jump_valid,
    output logic        m_clear_next_interrupt
);
    import mtre_pkg::*;

    mtre_cmd_t    cmd;
    mtre_status_t stat;

    // Sequencer.
    mtre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Registers, range store and output stage.
    mtre_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_datapath (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_action               (s_action),
        .s_fault_address        (s_fault_address),
        .s_access_kind          (s_access_kind),
        .s_resume_pc            (s_resume_pc),
        .s_delay_slot_kind      (s_delay_slot_kind),
        .s_entry_index          (s_entry_index),
        .s_odd_half             (s_odd_half),
        .s_range_start          (s_range_start),
        .s_range_end            (s_range_end),
        .s_register_select      (s_register_select),
        .s_register_value       (s_register_value),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_vector_pc            (m_vector_pc),
        .m_epc_out              (m_epc_out),
        .m_cause_out            (m_cause_out),
        .m_status_out           (m_status_out),
        .m_context_out          (m_context_out),
        .m_bad_address_out      (m_bad_address_out),
        .m_entry_high_out       (m_entry_high_out),
        .m_skip_jump_valid      (m_skip_jump_valid),
        .m_clear_next_interrupt (m_clear_next_interrupt),
        .cmd                    (cmd),
        .stat                   (stat)
    );

endmodule
